// ===== rtl/sha1mh_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 message hasher.
// Used by the core, schedule and round modules; depends on nothing.
package sha1mh_pkg;

  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_data;
    logic       step;
  } sched_ctrl_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic add;
  } round_ctrl_t;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [6:0] LastRound = 7'd79;

  localparam digest_t InitVector = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

// ===== rtl/sha1_message_hasher_core.sv =====
// Top level of the SHA-1 message hasher: stream ports, padding sequencer,
// digest output bank. Depends on sha1mh_pkg, sha1mh_sched and sha1mh_round.
//
//   channel   direction  tdata                tuser            tlast
//   s_axis    in         message_byte [7:0]   has_byte [0]     end_of_message
//   m_axis    out        digest_word [31:0]   word_index [2:0] last_word
//
// A byte beat is taken while idle; the beat that fills a block starts the
// rounds on the single round unit. An end beat pads byte by byte (a marker,
// then zeros, with an extra block of rounds if the length does not fit), then
// shifts in the 8 length bytes and runs the final rounds. The five digest
// beats wait in an output bank, so input is taken again while they drain.
// Reset is synchronous and restores the initial vector.
module sha1_message_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // message_byte
  input  logic [0:0]  s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast
);
  import sha1mh_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]  state, state_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] bit_count, bit_count_next;
  logic [6:0]  rnd, rnd_next;
  logic        finishing, finishing_next;
  logic        marked, marked_next;
  logic        len_done, len_done_next;
  logic        out_busy;
  logic [2:0]  out_idx;
  digest_t     bank;
  logic        bank_load;

  sched_ctrl_t sc;
  round_ctrl_t rc;
  logic [31:0] w_cur;
  digest_t     chain;
  logic        in_acc, out_acc;

  assign s_axis_tready = (state == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_busy;
  assign m_axis_tdata  = bank[0];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == 3'd4);

  sha1mh_sched u_sched (
    .clk   (clk),
    .ctrl  (sc),
    .w_cur (w_cur)
  );

  sha1mh_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rc),
    .rnd   (rnd),
    .w_cur (w_cur),
    .chain (chain)
  );

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    bit_count_next = bit_count;
    rnd_next       = rnd;
    finishing_next = finishing;
    marked_next    = marked;
    len_done_next  = len_done;
    bank_load      = 1'b0;
    sc             = '0;
    rc             = '0;
    unique case (state)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            sc.shift_byte  = 1'b1;
            sc.byte_data   = s_axis_tdata;
            fill_next      = fill + 6'd1;
            bit_count_next = bit_count + 64'd8;
          end
          if (s_axis_tuser[0] && fill == 6'd63) begin
            rc.load        = 1'b1;
            rnd_next       = '0;
            finishing_next = s_axis_tlast;
            marked_next    = 1'b0;
            len_done_next  = 1'b0;
            state_next     = StRound;
          end else if (s_axis_tlast) begin
            finishing_next = 1'b1;
            marked_next    = 1'b0;
            len_done_next  = 1'b0;
            state_next     = StPad;
          end
        end
      end
      StPad: begin
        sc.shift_byte = 1'b1;
        sc.byte_data  = marked ? 8'h00 : PadMarker;
        marked_next   = 1'b1;
        fill_next     = fill + 6'd1;
        if (fill == 6'd63) begin
          rc.load    = 1'b1;
          rnd_next   = '0;
          state_next = StRound;
        end else if (fill == 6'd55) begin
          state_next = StLen;
        end
      end
      StLen: begin
        sc.shift_byte  = 1'b1;
        sc.byte_data   = bit_count[63:56];
        bit_count_next = {bit_count[55:0], 8'h00};
        fill_next      = fill + 6'd1;
        if (fill == 6'd63) begin
          rc.load       = 1'b1;
          rnd_next      = '0;
          len_done_next = 1'b1;
          state_next    = StRound;
        end
      end
      StRound: begin
        rc.step  = 1'b1;
        sc.step  = 1'b1;
        rnd_next = rnd + 7'd1;
        if (rnd == LastRound) begin
          state_next = StAdd;
        end
      end
      StAdd: begin
        rc.add = 1'b1;
        priority if (finishing && len_done) begin
          state_next = StEmit;
        end else if (finishing) begin
          state_next = StPad;
        end else begin
          state_next = StIdle;
        end
      end
      StEmit: begin
        if (!out_busy) begin
          bank_load      = 1'b1;
          rc.init        = 1'b1;
          bit_count_next = '0;
          finishing_next = 1'b0;
          marked_next    = 1'b0;
          len_done_next  = 1'b0;
          state_next     = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      fill      <= '0;
      bit_count <= '0;
      rnd       <= '0;
      finishing <= 1'b0;
      marked    <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      bit_count <= bit_count_next;
      rnd       <= rnd_next;
      finishing <= finishing_next;
      marked    <= marked_next;
      len_done  <= len_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (bank_load) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (out_acc) begin
      out_idx <= out_idx + 3'd1;
      if (out_idx == 3'd4) begin
        out_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bank_load) begin
      bank <= chain;
    end else if (out_acc) begin
      bank <= {32'h0, bank[4:1]};
    end
  end

endmodule

// ===== rtl/sha1mh_sched.sv =====
// Block buffer and message schedule: gathers bytes into a 512-bit window and
// then slides it one word per round. Depends on sha1mh_pkg.
module sha1mh_sched (
  input  logic                    clk,
  input  sha1mh_pkg::sched_ctrl_t ctrl,
  output logic [31:0]             w_cur
);
  import sha1mh_pkg::*;

  logic [511:0] win;
  logic [31:0]  w_new;
  logic [31:0]  w_mix;

  assign w_cur = win[511:480];
  assign w_mix = win[511:480] ^ win[447:416] ^ win[255:224] ^ win[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      win <= {win[503:0], ctrl.byte_data};
    end else if (ctrl.step) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

// ===== rtl/sha1mh_round.sv =====
// Shared SHA-1 round unit with its working variables and the chain value.
// Depends on sha1mh_pkg.
module sha1mh_round (
  input  logic                    clk,
  input  logic                    rst,
  input  sha1mh_pkg::round_ctrl_t ctrl,
  input  logic [6:0]              rnd,
  input  logic [31:0]             w_cur,
  output sha1mh_pkg::digest_t     chain
);
  import sha1mh_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f;
  logic [31:0] a_next;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    a_next = {a[26:0], a[31:27]} + f + e + round_k(rnd) + w_cur;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctrl.step) begin
      a <= a_next;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      chain <= InitVector;
    end else if (ctrl.add) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

// ===== rtl/sha1mh_checker.sv =====
// Port-level checks for the SHA-1 message hasher, bound to the top level.
// Depends only on the top level's ports.
module sha1mh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled digest beat changed.");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
    else $error("Last flag does not match word index four.");

  a_words_follow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid
      && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("Digest words are not contiguous.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("Digest beat appeared right after the last word.");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("Input accepted right after an end beat.");

endmodule

bind sha1_message_hasher_core sha1mh_checker u_sha1mh_checker (.*);
